@@ design/md5_pkg.sv @@
// Package for the MD5 digest block: constants, state type, round tables.
// Depends on nothing; used by md5_message_digest, md5_buf and md5_round.
`default_nettype none
package md5_pkg;
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_FIRST = 8'h80;
  localparam int unsigned LENGTH_POS = 56;
  localparam int unsigned BLOCK_WORDS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_DONE
  } md5_state_t;

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;  6'd2: k = 32'h242070DB;
      6'd3: k = 32'hC1BDCEEE;  6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;  6'd8: k = 32'h698098D8;
      6'd9: k = 32'h8B44F7AF;  6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  // Rotate amount for a round
  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index for a round
  function automatic logic [3:0] round_g(input logic [5:0] r);
    logic [3:0] g;
    logic [3:0] rl;
    rl = r[3:0];
    unique case (r[5:4])
      2'd0: g = rl;
      2'd1: g = 4'((rl << 2) + rl + 4'd1);
      2'd2: g = 4'((rl << 1) + rl + 4'd5);
      default: g = 4'((rl << 3) - rl);
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

@@ design/md5_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface md5_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/md5_message_digest.sv @@
// MD5 digest top level: byte packing, padding sequencer and round loop.
// Depends on md5_pkg, md5_if, md5_buf, md5_round.
//
// Usage: send the message as little-endian 32-bit words on the in_ channel,
// byte_count giving the valid low bytes (5..7 act as 4), last_word on the
// final word. A non-last word with no bytes is dropped. After the last word
// one transaction on the out_ channel carries the digest words A..D.
// Each word is packed into the 16-word block buffer; a word that completes
// a block starts 64 rounds, one per cycle, each with its message word read
// ahead from the registered buffer memory, then a fold state adds the round
// words into the chaining words. The last word adds padding words (one per
// cycle) and one or two compressions.
// One item at a time: in_ready is low while a block is compressed, while
// padding runs, and while a digest waits; a stalled receiver holds the
// digest until out_ready. Reset returns the chaining words to the initial
// values and the buffer fill to zero; buffer contents are never read unwritten.
`default_nettype none
module md5_message_digest (
  input wire logic clk,
  input wire logic rst_n,
  md5_if.sink      in_ch,
  md5_if.source    out_ch
);
  import md5_pkg::*;

  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last_word;
  assign in_data_word  = in_ch.payload.data_word;
  assign in_byte_count = in_ch.payload.byte_count;
  assign in_last_word  = in_ch.payload.last_word;

  md5_state_t state_r, state_nxt;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] part_r;      // partial word being assembled
  logic [63:0] len_r;       // latched length for padding
  logic        final_r;     // current compression is the last of a message
  logic [6:0]  rnd_r;
  logic        lenpass_r;   // padding reached length words
  logic        len_pend_r;  // padding still to run after this compression

  logic [31:0] out_a_r, out_b_r, out_c_r, out_d_r;

  // Input byte packing
  logic [2:0]  cnt;
  logic        accept;
  logic [6:0]  sum;
  logic [63:0] comb;
  logic [31:0] wr_word;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [5:0]  fill_after;
  logic        full_block;

  assign accept = in_ch.valid && in_ch.ready;
  assign cnt = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;

  always_comb begin
    logic [63:0] masked;
    masked = 64'(in_data_word & ((cnt == 3'd4) ? 32'hFFFFFFFF :
                                 ((32'd1 << {cnt, 3'b000}) - 32'd1)));
    comb = 64'(part_r & ((32'd1 << {fill_r[1:0], 3'b000}) - 32'd1))
         | (masked << {fill_r[1:0], 3'b000});
    sum = 7'(fill_r) + 7'(cnt);
  end

  // Padding word generation
  logic [31:0] pad_word;
  logic [3:0]  pad_addr;
  always_comb begin
    pad_addr = fill_r[5:2];
    if (lenpass_r) begin
      pad_word = fill_r[2] ? len_r[63:32] : len_r[31:0];
    end else begin
      pad_word = (part_r & ((32'd1 << {fill_r[1:0], 3'b000}) - 32'd1))
               | (32'(PAD_FIRST) << {fill_r[1:0], 3'b000});
    end
  end

  // Memory write select
  logic pad_first_r;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill_r[5:2];
    wr_word = comb[31:0];
    if (state_r == ST_IDLE && accept && cnt != 3'd0) begin
      wr_en = 1'b1;
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
      wr_addr = pad_addr;
      wr_word = pad_first_r ? pad_word : (lenpass_r ? pad_word : 32'd0);
    end
  end
  assign fill_after = sum[5:0];
  assign full_block = sum[6];

  // Round unit and buffer
  logic [31:0] m_rd;
  logic [3:0]  rd_addr;
  logic [31:0] b_new;
  logic [5:0]  rnd_lo;
  assign rnd_lo = rnd_r[5:0];
  always_comb begin
    rd_addr = round_g(6'd0);
    if (state_r == ST_ROUND && rnd_r < 7'd63) rd_addr = round_g(6'(rnd_r + 7'd1));
  end
  md5_buf u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_word),
    .rd_addr(rd_addr), .rd_data(m_rd)
  );
  md5_round u_round (
    .rnd(rnd_lo), .a(a_r), .b(b_r), .c(c_r), .d(d_r), .m(m_rd), .b_new(b_new)
  );

  // Next state
  logic pad_done;
  assign pad_done = lenpass_r && fill_r == 6'd60;
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        if (full_block) state_nxt = ST_ROUND;
        else if (in_last_word) state_nxt = ST_PAD;
      end
      ST_ROUND: if (rnd_r == 7'd63) state_nxt = ST_FOLD;
      ST_FOLD: state_nxt = final_r ? ST_DONE : (len_pend_r ? ST_PAD : ST_IDLE);
      ST_PAD: if (pad_done || (fill_r[5:2] == 4'd15 && !lenpass_r)) state_nxt = ST_ROUND;
      ST_DONE: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.payload.word_a = out_a_r;
  assign out_ch.payload.word_b = out_b_r;
  assign out_ch.payload.word_c = out_c_r;
  assign out_ch.payload.word_d = out_d_r;

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      rnd_r <= '0;
      final_r <= 1'b0;
      len_pend_r <= 1'b0;
      lenpass_r <= 1'b0;
      pad_first_r <= 1'b0;
      h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          part_r <= comb[31:0];
          if (cnt == 3'd4 || (7'(fill_r[1:0]) + 7'(cnt)) >= 7'd4) part_r <= comb[63:32];
          fill_r <= fill_after;
          bits_r <= bits_r + 64'({cnt, 3'b000});
          rnd_r <= '0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          if (in_last_word) begin
            len_r <= bits_r + 64'({cnt, 3'b000});
            len_pend_r <= full_block;
            pad_first_r <= 1'b1;
            lenpass_r <= 1'b0;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_new;
        end
        ST_FOLD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          len_pend_r <= 1'b0;
          if (final_r) begin
            final_r <= 1'b0;
            fill_r <= '0;
            bits_r <= '0;
          end
        end
        ST_PAD: begin
          rnd_r <= '0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          pad_first_r <= 1'b0;
          // Block full before the length fits: compress, then pad again
          if (!lenpass_r && fill_r[5:2] == 4'd15) len_pend_r <= 1'b1;
          if (!lenpass_r && fill_r[5:2] == 4'd13 && !pad_first_r) begin
            lenpass_r <= 1'b1;
            fill_r <= 6'd56;
          end else if (pad_first_r && fill_r[5:2] == 4'd13) begin
            lenpass_r <= 1'b1;
            fill_r <= 6'd56;
          end else if (lenpass_r) begin
            fill_r <= 6'(fill_r + 6'd4);
            if (pad_done) begin
              final_r <= 1'b1;
              fill_r <= '0;
            end
          end else begin
            fill_r <= 6'({fill_r[5:2], 2'b00} + 6'd4);
          end
        end
        ST_DONE: begin
          h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
        end
        default: ;
      endcase
    end
  end

  // Capture digest for the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_FOLD && final_r) begin
      out_a_r <= h_r[0] + a_r; out_b_r <= h_r[1] + b_r;
      out_c_r <= h_r[2] + c_r; out_d_r <= h_r[3] + d_r;
    end
  end
endmodule
`default_nettype wire

@@ design/md5_buf.sv @@
// Block buffer memory: 16 words, one write and one registered read port.
// Depends on md5_pkg.
`default_nettype none
module md5_buf (
  input  wire  logic        clk,
  input  wire  logic        wr_en,
  input  wire  logic [3:0]  wr_addr,
  input  wire  logic [31:0] wr_data,
  input  wire  logic [3:0]  rd_addr,
  output logic [31:0]       rd_data
);
  import md5_pkg::*;
  logic [31:0] mem [BLOCK_WORDS];
  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ design/md5_round.sv @@
// One MD5 round step: mixing function, add chain and rotate.
// Depends on md5_pkg.
`default_nettype none
module md5_round (
  input  wire  logic [5:0]  rnd,
  input  wire  logic [31:0] a,
  input  wire  logic [31:0] b,
  input  wire  logic [31:0] c,
  input  wire  logic [31:0] d,
  input  wire  logic [31:0] m,
  output logic [31:0]       b_new
);
  import md5_pkg::*;
  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  s;
  // Select mixing function by stage
  always_comb begin
    case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = a + f + m + round_k(rnd);
    s = round_s(rnd);
    b_new = b + ((t << s) | (t >> (6'd32 - {1'b0, s})));
  end
endmodule
`default_nettype wire

@@ bench/md5_bench_pkg.sv @@
// Transaction types for the MD5 digest testbench: input word and digest.
// Depends on nothing; used by the checker and the testbench top.
package md5_bench_pkg;
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } word_item_t;

  typedef struct packed {
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } digest_item_t;
endpackage

@@ bench/md5_digest_checker.sv @@
// Checker for the MD5 digest block: absorbs accepted words into its own
// MD5 state, queues expected digests and compares each digest transaction.
// Depends on md5_bench_pkg.
module md5_digest_checker
  import md5_bench_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  word_item_t   in_item,
  input  logic         out_fire,
  input  digest_item_t out_item,
  output int           fail_count,
  output int           pending
);
  localparam logic [31:0] KTAB [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };
  localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                  6, 10, 15, 21};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_AT   = 6'd56;

  logic [31:0]  chain [4];
  logic [31:0]  blk [16];
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  digest_item_t digest_q [$];

  initial fail_count = 0;
  assign pending = digest_q.size();

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // Run the 64 rounds on the held block and fold into the chaining words
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g, stage;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      stage = r >> 4;
      case (stage)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3 * r + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7 * r) & 15; end
      endcase
      t = a + f + blk[g] + KTAB[r];
      a = d; d = c; c = b;
      b = b + rotl(t, ROT_TAB[(stage << 2) | (r & 3)]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic put_byte(input logic [7:0] v);
    blk[fill[5:2]][fill[1:0] * 8 +: 8] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endtask

  task automatic init_chain();
    chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE; chain[3] = 32'h10325476;
    fill = '0;
    msg_bits = '0;
  endtask

  // Absorb one word; on the last word pad, append the length, queue the digest
  task automatic absorb_word(input word_item_t w);
    int cnt;
    logic [63:0] len;
    cnt = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
    for (int i = 0; i < cnt; i++) begin
      put_byte(w.data_word[8 * i +: 8]);
      msg_bits += 64'd8;
    end
    if (w.last_word) begin
      len = msg_bits;
      put_byte(PAD_BYTE);
      while (fill != LEN_AT) put_byte(8'h00);
      for (int i = 0; i < 8; i++) put_byte(len[8 * i +: 8]);
      digest_q.push_back('{chain[0], chain[1], chain[2], chain[3]});
      init_chain();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] exp_v);
    $display("digest mismatch on %s: got %08h, expected %08h", what, got, exp_v);
    fail_count++;
  endtask

  // Compare a digest transaction with the oldest expected digest
  task automatic check_digest(input digest_item_t got);
    digest_item_t want;
    if (digest_q.size() == 0) begin
      $display("digest with none expected: %08h %08h %08h %08h",
               got.word_a, got.word_b, got.word_c, got.word_d);
      fail_count++;
    end else begin
      want = digest_q.pop_front();
      if (got.word_a !== want.word_a) report("word_a", got.word_a, want.word_a);
      if (got.word_b !== want.word_b) report("word_b", got.word_b, want.word_b);
      if (got.word_c !== want.word_c) report("word_c", got.word_c, want.word_c);
      if (got.word_d !== want.word_d) report("word_d", got.word_d, want.word_d);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      init_chain();
      for (int i = 0; i < 16; i++) blk[i] = '0;
      digest_q.delete();
    end else begin
      if (out_fire) check_digest(out_item);
      if (in_fire) absorb_word(in_item);
    end
  end
endmodule

@@ bench/md5_message_digest_test.sv @@
// Testbench top for md5_message_digest: drives messages as word streams with
// random idling, holds off the receiver, and gives the verdict.
// Depends on md5_pkg, md5_if, md5_bench_pkg, md5_digest_checker and the block.
module md5_message_digest_test;
  import md5_bench_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 500;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int CALM_AFTER     = 1100;

  logic clk;
  logic rst_n;
  int   words_sent;
  int   hold_cycles;
  logic hold_req;
  int   fail_count;
  int   pending;
  int   stall_cnt;
  int   msg_idx;

  md5_if #(.payload_t(word_item_t))   in_ch ();
  md5_if #(.payload_t(digest_item_t)) out_ch ();

  md5_message_digest u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  md5_digest_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_ch.valid && in_ch.ready),
    .in_item    (in_ch.payload),
    .out_fire   (out_ch.valid && out_ch.ready),
    .out_item   (out_ch.payload),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall bursts, one long hold on request, none late on
  initial begin
    out_ch.ready = 1'b0;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req && stall_cnt == 0) begin
        hold_req = 1'b0;
        stall_cnt = LONG_HOLD;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else if (words_sent < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  initial begin
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        hold_cycles = 0;
      else
        hold_cycles++;
      if (hold_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                           input logic last);
    word_item_t w;
    w.data_word = data;
    w.byte_count = cnt;
    w.last_word = last;
    in_ch.valid <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    // idle burst between words
    if (words_sent < CALM_AFTER && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Random message: mostly full words, some short or empty ones, random tail
  task automatic send_message(input int nwords);
    logic [2:0] cnt;
    for (int i = 0; i < nwords; i++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    words_sent = 0;
    hold_req = 1'b0;
    msg_idx = 0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, short and full words, oversize counts
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hFF636261, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hA5A5A5A5, 3'd5, 1'b1);
    send_word(32'h5A5A5A5A, 3'd6, 1'b1);
    send_word(32'hDEADBEEF, 3'd7, 1'b1);
    // empty non-last word is dropped; short non-last continues the stream
    send_word(32'h12345678, 3'd0, 1'b0);
    send_word(32'hCAFE0001, 3'd1, 1'b0);
    send_word(32'h87654321, 3'd4, 1'b0);
    send_word(32'h0, 3'd0, 1'b1);
    // 55 bytes: padding fits in one block
    for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);

    // Random messages, mostly short, a few long
    while (words_sent < RANDOM_ITEMS) begin
      msg_idx++;
      if (msg_idx == 30) hold_req = 1'b1;
      if (msg_idx == 60) drain_digests();
      if ($urandom_range(0, 15) == 0) send_message($urandom_range(14, 48));
      else send_message($urandom_range(0, 18));
    end

    drain_digests();
    repeat (150) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
design/md5_pkg.sv
design/md5_if.sv
design/md5_buf.sv
design/md5_round.sv
design/md5_message_digest.sv
bench/md5_bench_pkg.sv
bench/md5_digest_checker.sv
bench/md5_message_digest_test.sv
